// ===== sv/drc_pkg.sv =====
// types, sizes and shared definitions of the dedup report cache
`timescale 1ns / 1ps
package drc_pkg;

  localparam int Entries = 64;
  localparam int IdxW    = $clog2(Entries);
  localparam int CntW    = $clog2(Entries + 1);

  typedef struct packed {
    logic [21:0] proc_id;
    logic [47:0] proc_start;
    logic [1:0]  op_mask;
    logic [31:0] now_stamp;
  } in_t;

  typedef struct packed {
    logic        report;
    logic [21:0] report_id;
  } out_t;

  typedef struct packed {
    logic [21:0] id;
    logic [47:0] start;
    logic [1:0]  ops;
    logic [31:0] stamp;
  } entry_t;

  typedef struct packed {
    logic hit;
    logic start_eq;
    logic overlap;
    logic older;
  } cmp_t;

endpackage

// ===== sv/drc_ram.sv =====
// generic single write port ram with registered read
`timescale 1ns / 1ps
module drc_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/drc_cmp.sv =====
// shared compare unit: id hit, start match, mask overlap and stamp age
`timescale 1ns / 1ps
module drc_cmp (
  input  drc_pkg::entry_t entry_i,
  input  drc_pkg::in_t    item_i,
  input  logic [31:0]     old_stamp_i,
  output drc_pkg::cmp_t   cmp_o
);

  always_comb begin
    cmp_o.hit      = (entry_i.id == item_i.proc_id);
    cmp_o.start_eq = (entry_i.start == item_i.proc_start);
    cmp_o.overlap  = |(entry_i.ops & item_i.op_mask);
    cmp_o.older    = (entry_i.stamp < old_stamp_i);
  end

endmodule

// ===== sv/dedup_report_cache_lru_core.sv =====
// top level of the dedup report cache with lru replacement
//
//  channel | direction | handshake             | payload
//  in      | input     | in_valid_i/in_ready_o | in_data_i  (drc_pkg::in_t)
//  out     | output    | out_valid_o/out_ready_i | out_data_o (drc_pkg::out_t)
//
//  one transaction scans up to all occupied slots, at most 64
//  the scan reads one slot a cycle from the table ram; a hit in slot k ends it
//  a zero id skips the scan and goes straight to the result step, an empty table to the write step
//  slots fill in order, so a fill count marks the valid ones; reset clears it at once
//  in_ready_o is low from acceptance until the result enters the output register
//  a stalled output holds the block in its last step until the previous result is taken
`timescale 1ns / 1ps
module dedup_report_cache_lru_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  drc_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output drc_pkg::out_t out_data_o
);

  typedef enum logic [1:0] {
    IDLE,
    SCAN,
    WRITE,
    DONE
  } state_e;

  state_e                     state_q, state_d;
  logic [drc_pkg::CntW-1:0]   cnt_q, cnt_d;
  logic [drc_pkg::CntW-1:0]   addr_q, addr_d;
  logic [drc_pkg::IdxW-1:0]   chk_q, chk_d;
  logic                       dvalid_q, dvalid_d;
  logic                       have_old_q, have_old_d;
  logic [drc_pkg::IdxW-1:0]   old_idx_q, old_idx_d;
  logic [31:0]                old_stamp_q, old_stamp_d;
  drc_pkg::in_t               item_q, item_d;
  logic                       rep_q, rep_d;
  logic [drc_pkg::IdxW-1:0]   wr_idx_q, wr_idx_d;
  drc_pkg::entry_t            wr_entry_q, wr_entry_d;
  logic                       out_valid_q, out_valid_d;
  drc_pkg::out_t              out_q, out_d;

  logic                       rd_en;
  logic                       we;
  logic [$bits(drc_pkg::entry_t)-1:0] rdata;
  drc_pkg::entry_t            rd_entry;
  drc_pkg::cmp_t              cmp;
  drc_pkg::entry_t            new_entry;
  logic [drc_pkg::IdxW-1:0]   old_idx_n;
  logic                       last;

  assign rd_entry = drc_pkg::entry_t'(rdata);
  assign rd_en    = (state_q == SCAN) && (addr_q < cnt_q);
  assign we       = (state_q == WRITE);

  drc_ram #(
    .Width($bits(drc_pkg::entry_t)),
    .Depth(drc_pkg::Entries)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(wr_idx_q),
    .wdata_i(wr_entry_q),
    .re_i   (rd_en),
    .raddr_i(addr_q[drc_pkg::IdxW-1:0]),
    .rdata_o(rdata)
  );

  drc_cmp u_cmp (
    .entry_i    (rd_entry),
    .item_i     (item_q),
    .old_stamp_i(old_stamp_q),
    .cmp_o      (cmp)
  );

  always_comb begin
    new_entry.id    = item_q.proc_id;
    new_entry.start = item_q.proc_start;
    new_entry.ops   = item_q.op_mask;
    new_entry.stamp = item_q.now_stamp;
    last = ((drc_pkg::CntW'(chk_q) + drc_pkg::CntW'(1)) == cnt_q);
    old_idx_n = (!have_old_q || cmp.older) ? chk_q : old_idx_q;
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    addr_d      = addr_q;
    chk_d       = chk_q;
    dvalid_d    = rd_en;
    have_old_d  = have_old_q;
    old_idx_d   = old_idx_q;
    old_stamp_d = old_stamp_q;
    item_d      = item_q;
    rep_d       = rep_q;
    wr_idx_d    = wr_idx_q;
    wr_entry_d  = wr_entry_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;

    if (rd_en) begin
      addr_d = addr_q + drc_pkg::CntW'(1);
      chk_d  = addr_q[drc_pkg::IdxW-1:0];
    end

    case (state_q)
      IDLE: begin
        if (in_valid_i) begin
          item_d     = in_data_i;
          addr_d     = '0;
          have_old_d = 1'b0;
          rep_d      = 1'b1;
          if (in_data_i.proc_id == '0) begin
            rep_d   = 1'b0;
            state_d = DONE;
          end else if (cnt_q == '0) begin
            wr_idx_d         = '0;
            wr_entry_d.id    = in_data_i.proc_id;
            wr_entry_d.start = in_data_i.proc_start;
            wr_entry_d.ops   = in_data_i.op_mask;
            wr_entry_d.stamp = in_data_i.now_stamp;
            cnt_d            = drc_pkg::CntW'(1);
            state_d          = WRITE;
          end else begin
            state_d = SCAN;
          end
        end
      end
      SCAN: begin
        if (dvalid_q) begin
          if (cmp.hit) begin
            wr_idx_d         = chk_q;
            wr_entry_d       = rd_entry;
            wr_entry_d.stamp = item_q.now_stamp;
            if (cmp.start_eq) begin
              if (cmp.overlap) begin
                rep_d = 1'b0;
              end else begin
                wr_entry_d.ops = rd_entry.ops | item_q.op_mask;
              end
            end else begin
              wr_entry_d.start = item_q.proc_start;
              wr_entry_d.ops   = item_q.op_mask;
            end
            state_d = WRITE;
          end else begin
            have_old_d = 1'b1;
            old_idx_d  = old_idx_n;
            if (!have_old_q || cmp.older) begin
              old_stamp_d = rd_entry.stamp;
            end
            if (last) begin
              wr_entry_d = new_entry;
              if (cnt_q == drc_pkg::CntW'(drc_pkg::Entries)) begin
                wr_idx_d = old_idx_n;
              end else begin
                wr_idx_d = cnt_q[drc_pkg::IdxW-1:0];
                cnt_d    = cnt_q + drc_pkg::CntW'(1);
              end
              state_d = WRITE;
            end
          end
        end
      end
      WRITE: begin
        state_d = DONE;
      end
      DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d     = 1'b1;
          out_d.report    = rep_q;
          out_d.report_id = rep_q ? item_q.proc_id : '0;
          state_d         = IDLE;
        end
      end
      default: begin
        state_d = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= IDLE;
      cnt_q       <= '0;
      dvalid_q    <= 1'b0;
      have_old_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      dvalid_q    <= dvalid_d;
      have_old_q  <= have_old_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q      <= addr_d;
    chk_q       <= chk_d;
    old_idx_q   <= old_idx_d;
    old_stamp_q <= old_stamp_d;
    item_q      <= item_d;
    rep_q       <= rep_d;
    wr_idx_q    <= wr_idx_d;
    wr_entry_q  <= wr_entry_d;
    out_q       <= out_d;
  end

  assign in_ready_o  = (state_q == IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== sv/drc_checker.sv =====
// port level checks of the dedup report cache and their bind
`timescale 1ns / 1ps
module drc_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_o,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input drc_pkg::out_t out_data_o
);

  // one transaction at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while a transaction is in progress");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.report |-> out_data_o.report_id == '0)
    else $error("suppressed result carries an id");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.report |-> out_data_o.report_id != '0)
    else $error("reported result with zero id");

endmodule

bind dedup_report_cache_lru_core drc_checker u_drc_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_data_o (out_data_o)
);

// ===== sim/dedup_report_cache_lru_core_tb.sv =====
// testbench of the dedup report cache core: directed and random stimulus checked against a predictor
`timescale 1ns / 1ps
module dedup_report_cache_lru_core_tb;

  localparam int NumRandom  = 1600;
  localparam int PoolSize   = 100;
  localparam int DrainWait  = 80;
  localparam int CycleLimit = 1000000;
  localparam int ShowErrors = 10;

  logic          clk_i       = 1'b0;
  logic          rst_ni      = 1'b0;
  logic          in_valid_i  = 1'b0;
  logic          in_ready_o;
  drc_pkg::in_t  in_data_i   = '0;
  logic          out_valid_o;
  logic          out_ready_i = 1'b0;
  drc_pkg::out_t out_data_o;

  drc_pkg::in_t    pending_events[$];
  drc_pkg::out_t   expected_reports[$];
  drc_pkg::entry_t cache_tab [drc_pkg::Entries];

  int n_events_total = 0;
  int n_accepted     = 0;
  int n_checked      = 0;
  int n_errors       = 0;
  int cycle_cnt      = 0;
  int in_gap         = 0;
  int out_gap        = 0;
  int in_draw;
  int out_draw;
  bit calm_in        = 1'b0;
  bit calm_out       = 1'b0;

  dedup_report_cache_lru_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic logic [47:0] rand_start();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    return w[47:0];
  endfunction

  function automatic void add_event(logic [21:0] id, logic [47:0] start, logic [1:0] mask,
                                    logic [31:0] stamp);
    drc_pkg::in_t ev;
    ev.proc_id    = id;
    ev.proc_start = start;
    ev.op_mask    = mask;
    ev.now_stamp  = stamp;
    pending_events.push_back(ev);
  endfunction

  // scan in slot order: empty slot or id hit ends the scan, else track the oldest stamp
  function automatic drc_pkg::out_t predict_report(drc_pkg::in_t ev);
    drc_pkg::out_t   res;
    drc_pkg::entry_t fresh;
    int              oldest;
    logic [31:0]     oldest_stamp;
    bit              have_oldest;
    bit              placed;
    res.report    = 1'b1;
    res.report_id = ev.proc_id;
    if (ev.proc_id == '0) begin
      res = '0;
      return res;
    end
    fresh        = '{id: ev.proc_id, start: ev.proc_start, ops: ev.op_mask, stamp: ev.now_stamp};
    oldest       = 0;
    oldest_stamp = '0;
    have_oldest  = 1'b0;
    placed       = 1'b0;
    for (int i = 0; i < drc_pkg::Entries && !placed; i++) begin
      if (cache_tab[i].id == '0) begin
        cache_tab[i] = fresh;
        placed = 1'b1;
      end else if (cache_tab[i].id == ev.proc_id) begin
        cache_tab[i].stamp = ev.now_stamp;
        if (cache_tab[i].start == ev.proc_start) begin
          if ((cache_tab[i].ops & ev.op_mask) != '0) begin
            res = '0;
          end else begin
            cache_tab[i].ops = cache_tab[i].ops | ev.op_mask;
          end
        end else begin
          cache_tab[i].start = ev.proc_start;
          cache_tab[i].ops   = ev.op_mask;
        end
        placed = 1'b1;
      end else if (!have_oldest || cache_tab[i].stamp < oldest_stamp) begin
        have_oldest  = 1'b1;
        oldest_stamp = cache_tab[i].stamp;
        oldest       = i;
      end
    end
    if (!placed) begin
      cache_tab[oldest] = fresh;
    end
    return res;
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_gap     <= 0;
    end else if (in_valid_i && in_ready_o) begin
      expected_reports.push_back(predict_report(in_data_i));
      n_accepted <= n_accepted + 1;
      if (n_accepted % 50 == 49) begin
        calm_in <= ($urandom_range(0, 3) == 0);
      end
      in_draw = calm_in ? 0 : $urandom_range(0, 8);
      if (in_draw == 0 && pending_events.size() != 0) begin
        in_data_i <= pending_events.pop_front();
      end else begin
        in_valid_i <= 1'b0;
        in_gap     <= in_draw;
      end
    end else if (!in_valid_i) begin
      if (in_gap != 0) begin
        in_gap <= in_gap - 1;
      end else if (pending_events.size() != 0) begin
        in_data_i  <= pending_events.pop_front();
        in_valid_i <= 1'b1;
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      out_gap     <= 0;
    end else if (out_valid_o && out_ready_i) begin
      if (expected_reports.size() == 0) begin
        if (n_errors < ShowErrors) begin
          $display("%0t: result with nothing expected: report=%0b id=%0d",
                   $realtime, out_data_o.report, out_data_o.report_id);
        end
        n_errors++;
      end else if (out_data_o.report !== expected_reports[0].report ||
                   out_data_o.report_id !== expected_reports[0].report_id) begin
        if (n_errors < ShowErrors) begin
          $display("%0t: result %0d mismatch: expected report=%0b id=%0d, got report=%0b id=%0d",
                   $realtime, n_checked, expected_reports[0].report,
                   expected_reports[0].report_id, out_data_o.report, out_data_o.report_id);
        end
        n_errors++;
        void'(expected_reports.pop_front());
      end else begin
        void'(expected_reports.pop_front());
      end
      n_checked++;
      if (n_checked % 60 == 59) begin
        calm_out <= ($urandom_range(0, 3) == 0);
      end
      out_draw = calm_out ? 0 : $urandom_range(0, 8);
      if (out_draw != 0) begin
        out_ready_i <= 1'b0;
        out_gap     <= out_draw - 1;
      end
    end else if (out_gap != 0) begin
      out_gap <= out_gap - 1;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("dedup_report_cache_lru_core_tb: done, errors");
      $finish;
    end
  end

  initial begin
    logic [21:0] pool_id    [PoolSize];
    logic [47:0] pool_start [PoolSize];
    logic [21:0] id;
    logic [47:0] start;
    logic [1:0]  mask;
    logic [31:0] stamp;
    logic [31:0] tick;
    int          k;
    int          r;

    for (int i = 0; i < drc_pkg::Entries; i++) begin
      cache_tab[i] = '0;
    end

    // directed: zero id, overlap, merge, zero mask, id reuse, extremes
    add_event(22'd0, rand_start(), 2'd3, $urandom());
    add_event(22'd1, 48'd0, 2'd1, 32'd0);
    add_event(22'd1, 48'd0, 2'd1, 32'd5);
    add_event(22'd1, 48'd0, 2'd2, 32'd6);
    add_event(22'd1, 48'd0, 2'd3, 32'd7);
    add_event(22'd1, 48'd0, 2'd0, 32'd8);
    add_event(22'd1, 48'hFFFF_FFFF_FFFF, 2'd2, 32'd9);
    add_event(22'd1, 48'hFFFF_FFFF_FFFF, 2'd1, 32'd10);
    add_event(22'h3F_FFFF, 48'hFFFF_FFFF_FFFF, 2'd3, 32'hFFFF_FFFF);
    add_event(22'h3F_FFFF, 48'hFFFF_FFFF_FFFF, 2'd2, 32'd0);
    add_event(22'd0, 48'hFFFF_FFFF_FFFF, 2'd3, 32'hFFFF_FFFF);
    add_event(22'd2, 48'd0, 2'd0, 32'd0);
    add_event(22'd2, 48'd0, 2'd0, 32'd1);
    add_event(22'd2, 48'd0, 2'd1, 32'd1);
    add_event(22'd2, 48'h1234_5678_9ABC, 2'd3, 32'd2);
    add_event(22'h2A_AAAA, 48'hAAAA_AAAA_AAAA, 2'd2, 32'hAAAA_AAAA);
    add_event(22'h15_5555, 48'h5555_5555_5555, 2'd1, 32'h5555_5555);
    add_event(22'h2A_AAAA, 48'hAAAA_AAAA_AAAA, 2'd1, 32'd0);
    add_event(22'h15_5555, 48'h5555_5555_5555, 2'd1, 32'hFFFF_FFFF);

    // random: a pool larger than the table gives hits, refills and evictions
    for (int i = 0; i < PoolSize; i++) begin
      pool_id[i]    = (i % 4 == 0) ? 22'($urandom_range(1, 22'h3F_FFFF))
                                   : 22'($urandom_range(1, 120));
      pool_start[i] = rand_start();
    end
    tick = $urandom_range(0, 1000);
    for (int n = 0; n < NumRandom; n++) begin
      k = $urandom_range(0, PoolSize - 1);
      r = $urandom_range(0, 99);
      if (r < 3) begin
        id = '0;
      end else if (r < 8) begin
        id = 22'($urandom_range(1, 22'h3F_FFFF));
      end else begin
        id = pool_id[k];
      end
      r = $urandom_range(0, 99);
      if (r < 15) begin
        pool_start[k] = rand_start();
      end
      start = (r >= 95) ? rand_start() : pool_start[k];
      mask  = ($urandom_range(0, 9) == 0) ? 2'd0 : 2'($urandom_range(1, 3));
      r     = $urandom_range(0, 99);
      tick  = tick + 32'($urandom_range(0, 3));
      if (r < 10) begin
        stamp = $urandom();
      end else if (r < 15) begin
        stamp = '0;
      end else if (r < 20) begin
        stamp = 32'hFFFF_FFFF;
      end else if (r < 30) begin
        stamp = 32'($urandom_range(0, 7));
      end else begin
        stamp = tick;
      end
      add_event(id, start, mask, stamp);
    end
    n_events_total = pending_events.size();

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (n_accepted != n_events_total) @(posedge clk_i);
    while (expected_reports.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    if (expected_reports.size() != 0) begin
      n_errors++;
    end

    if (n_errors == 0) begin
      $display("dedup_report_cache_lru_core_tb: done, clean");
    end else begin
      $display("dedup_report_cache_lru_core_tb: done, errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/drc_pkg.sv
sv/drc_ram.sv
sv/drc_cmp.sv
sv/dedup_report_cache_lru_core.sv
sv/drc_checker.sv
sim/dedup_report_cache_lru_core_tb.sv
